// ===== sv/svpwm_pkg.sv =====
// Shared types and constants for the space vector PWM duty cycle block.
// No dependencies; used by space_vector_pwm_duty_top.
package svpwm_pkg;

    localparam int unsigned InW   = 16;
    localparam int unsigned TW    = 14;
    localparam int unsigned T3W   = 15;
    localparam int unsigned CmpW  = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 16;

    // Width of the scaled products and of the sector working values.
    localparam int unsigned ProdW = 32;
    // Width of the timing numerator, with headroom for T plus two products.
    localparam int unsigned NumW  = 34;

    // Division by 131072 and the extra halving of the first timing.
    localparam int unsigned ScaleSh = 17;
    localparam int unsigned NumSh   = ScaleSh + 1;
    // The offset is T / 8.
    localparam int unsigned OffSh   = 3;

    localparam logic [TW-1:0]   FullPeriodRst  = TW'(9000);
    localparam logic [T3W-1:0]  FullPeriod3Rst = T3W'(15588);
    localparam logic [CmpW-1:0] MaxCompareRst  = CmpW'(2160);
    localparam logic [CmpW-1:0] MinCompareRst  = CmpW'(12);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FULL_PERIOD       = 2'd0,
        CFG_FULL_PERIOD_SQRT3 = 2'd1,
        CFG_MAX_COMPARE       = 2'd2,
        CFG_MIN_COMPARE       = 2'd3
    } t_cfg_reg;

    // Sectors that share one timing formula.
    typedef enum logic [1:0] {
        GRP_S14 = 2'd0,
        GRP_S25 = 2'd1,
        GRP_S36 = 2'd2
    } t_grp;

endpackage

// ===== sv/space_vector_pwm_duty_top.sv =====
// An accepted request passes through r_ua/r_ub, r_x/r_y/r_z, r_ta3, r_tb4 and the output registers.
// Throughput: one request per cycle; a request may enter in every cycle in which o_ready is high.
// The pipeline advances as a whole whenever the output register is empty or taken.
// Reset (synchronous, active low) clears all valid bits and loads the register
// defaults: full period 9000, sqrt3 period 15588, max compare 2160, min compare 12.
// Depends on svpwm_pkg.
module space_vector_pwm_duty_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [svpwm_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [svpwm_pkg::CfgDataW-1:0]      i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [svpwm_pkg::InW-1:0]    i_v_alpha,
    input  logic signed [svpwm_pkg::InW-1:0]    i_v_beta,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [svpwm_pkg::CmpW-1:0]          o_compare_a,
    output logic [svpwm_pkg::CmpW-1:0]          o_compare_b,
    output logic [svpwm_pkg::CmpW-1:0]          o_compare_c
);

    localparam int unsigned ProdW = svpwm_pkg::ProdW;
    localparam int unsigned NumW  = svpwm_pkg::NumW;
    localparam int unsigned CmpW  = svpwm_pkg::CmpW;
    localparam int unsigned TW    = svpwm_pkg::TW;
    localparam int unsigned T3W   = svpwm_pkg::T3W;

    // Signed division by 2^17, truncating toward zero, wrapped to 16 bits.
    function automatic logic [CmpW-1:0] f_div_scale(input logic signed [ProdW-1:0] v);
        logic signed [ProdW-1:0] adj;
        logic signed [ProdW-1:0] q;
        adj = v + $signed({{(ProdW-svpwm_pkg::ScaleSh){1'b0}},
                           {svpwm_pkg::ScaleSh{v[ProdW-1]}}});
        q   = adj >>> svpwm_pkg::ScaleSh;
        return q[CmpW-1:0];
    endfunction

    function automatic logic [CmpW-1:0] f_limit(
        input logic [CmpW-1:0] v,
        input logic [CmpW-1:0] vmax,
        input logic [CmpW-1:0] vmin
    );
        logic [CmpW-1:0] c;
        c = (v > vmax) ? vmax : v;
        return (c < vmin) ? '0 : c;
    endfunction

    // Configuration registers.
    logic [TW-1:0]   r_t;
    logic [T3W-1:0]  r_t3;
    logic [CmpW-1:0] r_max;
    logic [CmpW-1:0] r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t   <= svpwm_pkg::FullPeriodRst;
            r_t3  <= svpwm_pkg::FullPeriod3Rst;
            r_max <= svpwm_pkg::MaxCompareRst;
            r_min <= svpwm_pkg::MinCompareRst;
        end else if (i_cfg_we) begin
            unique case (svpwm_pkg::t_cfg_reg'(i_cfg_idx))
                svpwm_pkg::CFG_FULL_PERIOD:       r_t   <= i_cfg_wdata[TW-1:0];
                svpwm_pkg::CFG_FULL_PERIOD_SQRT3: r_t3  <= i_cfg_wdata[T3W-1:0];
                svpwm_pkg::CFG_MAX_COMPARE:       r_max <= i_cfg_wdata[CmpW-1:0];
                svpwm_pkg::CFG_MIN_COMPARE:       r_min <= i_cfg_wdata[CmpW-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves when the output register can take a new value.
    logic w_adv;
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end
    assign o_valid = r_v5;

    // Stage 1: scale alpha and beta.
    logic signed [ProdW-1:0] n_ua, n_ub, r_ua, r_ub;
    assign n_ua = ProdW'(i_v_alpha * $signed({1'b0, r_t3}));
    assign n_ub = ProdW'(-(i_v_beta * $signed({1'b0, r_t})));

    // Stage 2: X, Y, Z and sector group.
    logic signed [ProdW-1:0] w_sum, w_dif, w_sum_adj, w_dif_adj;
    logic signed [ProdW-1:0] n_y, n_z, r_x, r_y, r_z;
    svpwm_pkg::t_grp n_grp, r_grp2, r_grp3;

    always_comb begin
        w_sum     = r_ub + r_ua;
        w_dif     = r_ub - r_ua;
        w_sum_adj = w_sum + $signed({{(ProdW-1){1'b0}}, w_sum[ProdW-1]});
        w_dif_adj = w_dif + $signed({{(ProdW-1){1'b0}}, w_dif[ProdW-1]});
        n_y       = w_sum_adj >>> 1;
        n_z       = w_dif_adj >>> 1;
        // Ties on zero go to the sector the sign tests reach first.
        if (n_y[ProdW-1]) begin
            if (n_z[ProdW-1])              n_grp = svpwm_pkg::GRP_S25;
            else if (r_ub <= 0)            n_grp = svpwm_pkg::GRP_S14;
            else                           n_grp = svpwm_pkg::GRP_S36;
        end else begin
            if (!n_z[ProdW-1])             n_grp = svpwm_pkg::GRP_S25;
            else if (r_ub <= 0)            n_grp = svpwm_pkg::GRP_S36;
            else                           n_grp = svpwm_pkg::GRP_S14;
        end
    end

    // Stage 3: first timing and the scaled X, Y, Z steps.
    logic signed [NumW-1:0] w_t, w_x, w_y, w_z, w_num, w_num_adj, w_q;
    logic [CmpW-1:0] n_ta, r_ta3, r_dx, r_dy, r_dz;

    always_comb begin
        w_t = $signed({{(NumW-TW){1'b0}}, r_t});
        w_x = NumW'(r_x);
        w_y = NumW'(r_y);
        w_z = NumW'(r_z);
        unique case (r_grp2)
            svpwm_pkg::GRP_S14: w_num = w_t + w_x - w_z;
            svpwm_pkg::GRP_S25: w_num = w_t + w_y - w_z;
            default:            w_num = w_t - w_x + w_y;
        endcase
        // Halving then dividing by 2^17, both toward zero, equals one
        // truncating division by 2^18.
        w_num_adj = w_num + $signed({{(NumW-svpwm_pkg::NumSh){1'b0}},
                                     {svpwm_pkg::NumSh{w_num[NumW-1]}}});
        w_q  = w_num_adj >>> svpwm_pkg::NumSh;
        n_ta = w_q[CmpW-1:0]
             + {{(CmpW-TW+svpwm_pkg::OffSh){1'b0}}, r_t[TW-1:svpwm_pkg::OffSh]};
    end

    // Stage 4: remaining timings, each built from the wrapped earlier one.
    logic [CmpW-1:0] n_tb, n_tc, r_ta4, r_tb4, r_tc4;

    always_comb begin
        unique case (r_grp3)
            svpwm_pkg::GRP_S14: begin
                n_tb = r_ta3 + r_dz;
                n_tc = n_tb - r_dx;
            end
            svpwm_pkg::GRP_S25: begin
                n_tb = r_ta3 + r_dz;
                n_tc = r_ta3 - r_dy;
            end
            default: begin
                n_tc = r_ta3 - r_dy;
                n_tb = n_tc + r_dx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ua   <= n_ua;
            r_ub   <= n_ub;

            r_x    <= r_ub;
            r_y    <= n_y;
            r_z    <= n_z;
            r_grp2 <= n_grp;

            r_ta3  <= n_ta;
            r_dx   <= f_div_scale(r_x);
            r_dy   <= f_div_scale(r_y);
            r_dz   <= f_div_scale(r_z);
            r_grp3 <= r_grp2;

            r_ta4  <= r_ta3;
            r_tb4  <= n_tb;
            r_tc4  <= n_tc;

            o_compare_a <= f_limit(r_ta4, r_max, r_min);
            o_compare_b <= f_limit(r_tb4, r_max, r_min);
            o_compare_c <= f_limit(r_tc4, r_max, r_min);
        end
    end

endmodule
